FILE: sv/catmull_rom_interpolator_defines.svh
// Assertion macros for the spline interpolator checker
`ifndef CATMULL_ROM_INTERPOLATOR_DEFINES_SVH
`define CATMULL_ROM_INTERPOLATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define CRM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// condition that must never be seen outside reset
`define CRM_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: sv/crm_pkg.sv
// Types, widths and constants shared by the spline interpolator
package crm_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;

    // coefficient width, signed t width and Horner intermediate widths
    localparam int CW    = COORD_BITS + 4;
    localparam int TW    = FRAC_BITS + 2;
    localparam int M1W   = CW + TW;
    localparam int H1W   = M1W + 1;
    localparam int M2W   = H1W + TW;
    localparam int H2W   = M2W + 1;
    localparam int M3W   = H2W + TW;
    localparam int SW    = M3W + 1;
    localparam int LO_W  = H2W / 2;
    localparam int HI_W  = H2W - LO_W;
    localparam int SHR   = 3 * FRAC_BITS + 1;
    localparam int QW    = SW - SHR;

    // request to result, in cycles
    localparam int CRM_LATENCY = 9;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point0_x;
        logic signed [COORD_BITS-1:0] point0_y;
        logic signed [COORD_BITS-1:0] point1_x;
        logic signed [COORD_BITS-1:0] point1_y;
        logic signed [COORD_BITS-1:0] point2_x;
        logic signed [COORD_BITS-1:0] point2_y;
        logic signed [COORD_BITS-1:0] point3_x;
        logic signed [COORD_BITS-1:0] point3_y;
        logic        [FRAC_BITS:0]    frac_t;
    } crm_req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         clipped;
    } crm_res_t;

    typedef struct packed {
        logic signed [CW-1:0]         a;
        logic signed [CW-1:0]         b;
        logic signed [CW-1:0]         c;
        logic signed [COORD_BITS-1:0] p1;
    } crm_coef_t;

endpackage

FILE: sv/crm_coeff.sv
// Coefficient stage: forms the cubic's coefficients for both axes
module crm_coeff
    import crm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  crm_req_t             req,
    output logic                 out_valid,
    output crm_coef_t            coef_x,
    output crm_coef_t            coef_y,
    output logic [FRAC_BITS:0]   t
);

    function automatic crm_coef_t axis_coef(
        input logic signed [COORD_BITS-1:0] p0,
        input logic signed [COORD_BITS-1:0] p1,
        input logic signed [COORD_BITS-1:0] p2,
        input logic signed [COORD_BITS-1:0] p3
    );
        logic signed [CW-1:0] e0;
        logic signed [CW-1:0] e1;
        logic signed [CW-1:0] e2;
        logic signed [CW-1:0] e3;
        crm_coef_t            r;
        e0   = CW'(p0);
        e1   = CW'(p1);
        e2   = CW'(p2);
        e3   = CW'(p3);
        r.a  = e2 - e0;
        r.b  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        r.c  = ((e1 <<< 1) + e1) - e0 - ((e2 <<< 1) + e2) + e3;
        r.p1 = p1;
        return r;
    endfunction

    logic                 valid_reg;
    crm_coef_t            coef_x_reg;
    crm_coef_t            coef_y_reg;
    logic [FRAC_BITS:0]   t_reg;
    crm_coef_t            coef_x_next;
    crm_coef_t            coef_y_next;

    assign coef_x_next = axis_coef(req.point0_x, req.point1_x, req.point2_x, req.point3_x);
    assign coef_y_next = axis_coef(req.point0_y, req.point1_y, req.point2_y, req.point3_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_x_reg <= coef_x_next;
        coef_y_reg <= coef_y_next;
        t_reg      <= req.frac_t;
    end

    assign out_valid = valid_reg;
    assign coef_x    = coef_x_reg;
    assign coef_y    = coef_y_reg;
    assign t         = t_reg;

endmodule

FILE: sv/crm_horner.sv
// Seven-stage Horner evaluation of one axis, exact width throughout
module crm_horner
    import crm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  crm_coef_t             coef,
    input  logic [FRAC_BITS:0]    t,
    output logic                  out_valid,
    output logic signed [SW-1:0]  sum
);

    logic [6:0]                   v_reg;

    logic signed [M1W-1:0]        m1_reg;
    logic signed [CW-1:0]         b1_reg;
    logic signed [CW-1:0]         a1_reg;
    logic signed [COORD_BITS-1:0] p1_1_reg;
    logic [FRAC_BITS:0]           t1_reg;

    logic signed [H1W-1:0]        h1_reg;
    logic signed [CW-1:0]         a2_reg;
    logic signed [COORD_BITS-1:0] p1_2_reg;
    logic [FRAC_BITS:0]           t2_reg;

    logic signed [M2W-1:0]        m2_reg;
    logic signed [CW-1:0]         a3_reg;
    logic signed [COORD_BITS-1:0] p1_3_reg;
    logic [FRAC_BITS:0]           t3_reg;

    logic signed [H2W-1:0]        h2_reg;
    logic signed [COORD_BITS-1:0] p1_4_reg;
    logic [FRAC_BITS:0]           t4_reg;

    logic signed [LO_W+TW:0]      plo_reg;
    logic signed [HI_W+TW-1:0]    phi_reg;
    logic signed [COORD_BITS-1:0] p1_5_reg;

    logic signed [M3W-1:0]        m3_reg;
    logic signed [COORD_BITS-1:0] p1_6_reg;

    logic signed [SW-1:0]         sum_reg;

    logic signed [TW-1:0]         ts0;
    logic signed [TW-1:0]         ts2;
    logic signed [TW-1:0]         ts4;
    logic signed [M1W-1:0]        m1_next;
    logic signed [H1W-1:0]        h1_next;
    logic signed [M2W-1:0]        m2_next;
    logic signed [H2W-1:0]        h2_next;
    logic signed [LO_W+TW:0]      plo_next;
    logic signed [HI_W+TW-1:0]    phi_next;
    logic signed [M3W-1:0]        m3_next;
    logic signed [SW-1:0]         sum_next;

    assign ts0 = $signed({1'b0, t});
    assign ts2 = $signed({1'b0, t2_reg});
    assign ts4 = $signed({1'b0, t4_reg});

    assign m1_next  = M1W'($signed(coef.c)) * M1W'(ts0);
    assign h1_next  = H1W'(m1_reg) + H1W'($signed({b1_reg, {FRAC_BITS{1'b0}}}));
    assign m2_next  = M2W'(h1_reg) * M2W'(ts2);
    assign h2_next  = H2W'(m2_reg) + H2W'($signed({a3_reg, {(2*FRAC_BITS){1'b0}}}));
    // last multiply split in two halves
    assign plo_next = (LO_W+TW+1)'($signed({1'b0, h2_reg[LO_W-1:0]}))
                    * (LO_W+TW+1)'(ts4);
    assign phi_next = (HI_W+TW)'($signed(h2_reg[H2W-1:LO_W])) * (HI_W+TW)'(ts4);
    assign m3_next  = M3W'($signed({phi_reg, {LO_W{1'b0}}})) + M3W'(plo_reg);
    // constant term plus rounding half: (2p1 + 1) << 3F
    assign sum_next = SW'(m3_reg)
                    + SW'($signed({p1_6_reg, 1'b1, {(3*FRAC_BITS){1'b0}}}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg   <= m1_next;
        b1_reg   <= coef.b;
        a1_reg   <= coef.a;
        p1_1_reg <= coef.p1;
        t1_reg   <= t;

        h1_reg   <= h1_next;
        a2_reg   <= a1_reg;
        p1_2_reg <= p1_1_reg;
        t2_reg   <= t1_reg;

        m2_reg   <= m2_next;
        a3_reg   <= a2_reg;
        p1_3_reg <= p1_2_reg;
        t3_reg   <= t2_reg;

        h2_reg   <= h2_next;
        p1_4_reg <= p1_3_reg;
        t4_reg   <= t3_reg;

        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        p1_5_reg <= p1_4_reg;

        m3_reg   <= m3_next;
        p1_6_reg <= p1_5_reg;

        sum_reg  <= sum_next;
    end

    assign out_valid = v_reg[6];
    assign sum       = sum_reg;

endmodule

FILE: sv/crm_round.sv
// Output stage: shift down, saturate both axes, flag clipping
module crm_round
    import crm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [SW-1:0]  sum_x,
    input  logic signed [SW-1:0]  sum_y,
    output logic                  done,
    output crm_res_t              res
);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] value;
        logic                         clip;
    } crm_sat_t;

    function automatic crm_sat_t sat_axis(input logic signed [SW-1:0] s);
        logic signed [QW-1:0] q;
        crm_sat_t             r;
        q = QW'(s >>> SHR);
        if ((&q[QW-1:COORD_BITS-1]) || !(|q[QW-1:COORD_BITS-1]))
        begin
            r.value = q[COORD_BITS-1:0];
            r.clip  = 1'b0;
        end
        else
        begin
            r.value = q[QW-1] ? COORD_MIN : COORD_MAX;
            r.clip  = 1'b1;
        end
        return r;
    endfunction

    crm_sat_t  sx;
    crm_sat_t  sy;
    crm_res_t  res_next;
    crm_res_t  res_reg;
    logic      done_reg;

    assign sx = sat_axis(sum_x);
    assign sy = sat_axis(sum_y);

    always_comb
    begin
        res_next.out_x   = sx.value;
        res_next.out_y   = sy.value;
        res_next.clipped = sx.clip | sy.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: sv/catmull_rom_interpolator.sv
// Top level of the 2D Catmull-Rom spline interpolator
//
//   channel   strobe            payload     direction
//   request   start (& !busy)   req         in
//   result    done              res         out
//
// One request per cycle, every cycle; busy stays low.
// Result appears on done after the coefficient stage,
// seven Horner stages (three multiplies by t, the last split in two halves) and the output stage.
// Reset clears only the valid bits; data registers are not reset.
// Nothing stalls: results are shown for one cycle and must be taken then.
module catmull_rom_interpolator
    import crm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  crm_req_t  req,
    output logic      done,
    output crm_res_t  res
);

    logic                  coef_valid;
    crm_coef_t             coef_x;
    crm_coef_t             coef_y;
    logic [FRAC_BITS:0]    t;
    logic                  valid_x;
    logic                  valid_y;
    logic signed [SW-1:0]  sum_x;
    logic signed [SW-1:0]  sum_y;

    assign busy = 1'b0;

    crm_coeff u_coeff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .req       (req),
        .out_valid (coef_valid),
        .coef_x    (coef_x),
        .coef_y    (coef_y),
        .t         (t)
    );

    crm_horner u_horner_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .coef      (coef_x),
        .t         (t),
        .out_valid (valid_x),
        .sum       (sum_x)
    );

    crm_horner u_horner_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .coef      (coef_y),
        .t         (t),
        .out_valid (valid_y),
        .sum       (sum_y)
    );

    crm_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_x & valid_y),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .done      (done),
        .res       (res)
    );

endmodule

FILE: sv/crm_checker.sv
// Port-level checker for the spline interpolator, bound to the top level
`include "catmull_rom_interpolator_defines.svh"

module crm_checker
    import crm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input crm_req_t  req,
    input logic      done,
    input crm_res_t  res
);

    `CRM_ASSERT_NEVER(a_never_busy, busy, "busy raised on a streaming block")
    `CRM_ASSERT_IMPL(a_req_gives_result, start && !busy, ##CRM_LATENCY done, "request lost")
    `CRM_ASSERT_IMPL(a_result_had_req, done, $past(start && !busy, CRM_LATENCY), "result invented")
    `CRM_ASSERT_IMPL(a_clip_at_limit, done && res.clipped, (res.out_x == COORD_MAX || res.out_x == COORD_MIN || res.out_y == COORD_MAX || res.out_y == COORD_MIN), "clipped without a saturated axis")

endmodule

bind catmull_rom_interpolator crm_checker u_crm_checker (.*);
